/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the button classifier.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on i_clk, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion clocked on i_clk that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/tbpc_pkg.sv */
// Package of the two-button press-and-hold classifier.
// Holds field widths, the classifier state type, register indexes and the
// wrap-around elapsed-time function. Depends on nothing.
package tbpc_pkg;

    // Width of the timestamp field and of the stored stamps.
    localparam int STAMP_W  = 32;
    // Time differences are taken modulo 2^TIME_BITS (16 to 64).
    localparam int TIME_BITS = 32;
    // Width in which the subtraction is carried out before it wraps.
    localparam int DIFF_W   = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;
    // Width of the configuration data.
    localparam int CFG_W    = 16;

    typedef logic [STAMP_W-1:0]   t_stamp;
    typedef logic [TIME_BITS-1:0] t_elapsed;
    typedef logic [CFG_W-1:0]     t_cfg;

    // Configuration register indexes.
    typedef enum logic {
        REG_PRESS_TIME = 1'b0,
        REG_HOLD_TIME  = 1'b1
    } t_reg_index;

    // Classifier states, encoded as on the switch_state output.
    typedef enum logic [2:0] {
        ST_IDLE          = 3'd0,
        ST_STOP_PRESSED  = 3'd1,
        ST_CYCLE_PRESSED = 3'd2,
        ST_BOTH_PRESSED  = 3'd3,
        ST_STOP_HELD     = 3'd4,
        ST_CYCLE_HELD    = 3'd5,
        ST_BOTH_HELD     = 3'd6
    } t_state;

    localparam logic [CFG_W-1:0] PRESS_TIME_RESET = CFG_W'(50);
    localparam logic [CFG_W-1:0] HOLD_TIME_RESET  = CFG_W'(1000);

    // Time since a stamp, wrapped to TIME_BITS bits.
    function automatic t_elapsed elapsed(input t_stamp now, input t_stamp stamp);
        logic [DIFF_W-1:0] diff;
        diff = DIFF_W'(now) - DIFF_W'(stamp);
        return diff[TIME_BITS-1:0];
    endfunction

endpackage

/* sv/two_button_press_hold_classifier.sv */
// Top level of the two-button press-and-hold classifier.
// Depends on tbpc_pkg and on assert_macros.svh for its checks.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one tick: the stop and
//   cycle button levels and the free-running millisecond time.
// - Output channel (o_out_valid / i_out_ready) returns one item per tick:
//   the classifier state, a changed flag and both button levels.
// - Configuration channel (i_cfg_valid / o_cfg_ready) writes press_time
//   (index 0) or hold_time (index 1); it is always ready and is meant to be
//   used only while no tick is in flight.
// - An accepted tick lands in the input register; its result is written
//   to the output register once that register is empty or being taken,
//   which raises o_out_valid.
// - Throughput is one tick per clock while the receiver takes results: the classifier state and stamps are
//   updated in a single pass as the tick moves from input to output register.
// - When the receiver stalls, the result holds and the input register still
//   takes one more tick; after that o_in_ready drops until space frees up.
// - Synchronous reset returns the classifier to idle, clears the stamps and
//   button history and reloads press_time = 50 and hold_time = 1000.
module two_button_press_hold_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Tick input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_stop_level,
    input  logic                      i_cycle_level,
    input  logic [tbpc_pkg::STAMP_W-1:0] i_time_now,
    // Result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_switch_state,
    output logic                      o_state_changed,
    output logic                      o_stop_coil,
    output logic                      o_cycle_coil,
    // Configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [tbpc_pkg::CFG_W-1:0] i_cfg_data
);

    // Configuration registers.
    tbpc_pkg::t_cfg r_press_time;
    tbpc_pkg::t_cfg r_hold_time;

    // Input register.
    logic              r_in_valid;
    logic              r_stop;
    logic              r_cycle;
    tbpc_pkg::t_stamp  r_now;

    // Classifier state.
    tbpc_pkg::t_state  r_state;
    tbpc_pkg::t_state  n_state;
    logic              r_stop_was;
    logic              r_cycle_was;
    tbpc_pkg::t_stamp  r_stop_stamp;
    tbpc_pkg::t_stamp  n_stop_stamp;
    tbpc_pkg::t_stamp  r_cycle_stamp;
    tbpc_pkg::t_stamp  n_cycle_stamp;
    tbpc_pkg::t_stamp  r_start_stamp;
    tbpc_pkg::t_stamp  n_start_stamp;
    logic              r_hold_fired;
    logic              n_hold_fired;

    // Output register.
    logic              r_out_valid;
    tbpc_pkg::t_state  r_out_state;
    logic              r_out_changed;
    logic              r_out_stop;
    logic              r_out_cycle;

    logic              advance;
    tbpc_pkg::t_state  raw;
    tbpc_pkg::t_stamp  recent;
    logic              press_met;
    logic              hold_met;

    // The tick in the input register moves on when the output can take it.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_switch_state  = r_out_state;
    assign o_state_changed = r_out_changed;
    assign o_stop_coil     = r_out_stop;
    assign o_cycle_coil    = r_out_cycle;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time <= tbpc_pkg::PRESS_TIME_RESET;
            r_hold_time  <= tbpc_pkg::HOLD_TIME_RESET;
        end else if (i_cfg_valid) begin
            unique case (tbpc_pkg::t_reg_index'(i_cfg_index))
                tbpc_pkg::REG_PRESS_TIME: r_press_time <= i_cfg_data;
                tbpc_pkg::REG_HOLD_TIME:  r_hold_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_stop  <= i_stop_level;
            r_cycle <= i_cycle_level;
            r_now   <= i_time_now;
        end
    end

    // Press stamps, the current combination, the most recent press and the press and hold checks.
    always_comb begin
        n_stop_stamp  = (r_stop && !r_stop_was) ? r_now : r_stop_stamp;
        n_cycle_stamp = (r_cycle && !r_cycle_was) ? r_now : r_cycle_stamp;

        priority if (r_stop && r_cycle) begin
            raw    = tbpc_pkg::ST_BOTH_PRESSED;
            recent = (n_cycle_stamp > n_stop_stamp) ? n_cycle_stamp : n_stop_stamp;
        end else if (r_stop) begin
            raw    = tbpc_pkg::ST_STOP_PRESSED;
            recent = n_stop_stamp;
        end else if (r_cycle) begin
            raw    = tbpc_pkg::ST_CYCLE_PRESSED;
            recent = n_cycle_stamp;
        end else begin
            raw    = tbpc_pkg::ST_IDLE;
            recent = '0;
        end

        press_met = tbpc_pkg::elapsed(r_now, recent)
                    >= tbpc_pkg::TIME_BITS'(r_press_time);
        hold_met  = tbpc_pkg::elapsed(r_now, r_start_stamp)
                    >= tbpc_pkg::TIME_BITS'(r_hold_time);
    end

    // Next state of the classifier.
    always_comb begin
        n_state       = r_state;
        n_start_stamp = r_start_stamp;
        n_hold_fired  = r_hold_fired;
        unique case (r_state)
            tbpc_pkg::ST_IDLE: begin
                if (raw != tbpc_pkg::ST_IDLE && press_met) begin
                    n_state       = raw;
                    n_start_stamp = recent;
                    n_hold_fired  = 1'b0;
                end
            end
            tbpc_pkg::ST_STOP_PRESSED,
            tbpc_pkg::ST_CYCLE_PRESSED,
            tbpc_pkg::ST_BOTH_PRESSED: begin
                if (raw != r_state) begin
                    n_state       = tbpc_pkg::ST_IDLE;
                    n_start_stamp = '0;
                end else if (!r_hold_fired && hold_met) begin
                    n_hold_fired = 1'b1;
                    unique case (r_state)
                        tbpc_pkg::ST_STOP_PRESSED:  n_state = tbpc_pkg::ST_STOP_HELD;
                        tbpc_pkg::ST_CYCLE_PRESSED: n_state = tbpc_pkg::ST_CYCLE_HELD;
                        default:                    n_state = tbpc_pkg::ST_BOTH_HELD;
                    endcase
                end
            end
            tbpc_pkg::ST_STOP_HELD: begin
                if (!r_stop) n_state = tbpc_pkg::ST_IDLE;
            end
            tbpc_pkg::ST_CYCLE_HELD: begin
                if (!r_cycle) n_state = tbpc_pkg::ST_IDLE;
            end
            tbpc_pkg::ST_BOTH_HELD: begin
                if (!r_stop || !r_cycle) n_state = tbpc_pkg::ST_IDLE;
            end
            default: ;
        endcase
    end

    // Classifier state register, updated once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tbpc_pkg::ST_IDLE;
            r_stop_was    <= 1'b0;
            r_cycle_was   <= 1'b0;
            r_stop_stamp  <= '0;
            r_cycle_stamp <= '0;
            r_start_stamp <= '0;
            r_hold_fired  <= 1'b0;
        end else if (advance) begin
            r_state       <= n_state;
            r_stop_was    <= r_stop;
            r_cycle_was   <= r_cycle;
            r_stop_stamp  <= n_stop_stamp;
            r_cycle_stamp <= n_cycle_stamp;
            r_start_stamp <= n_start_stamp;
            r_hold_fired  <= n_hold_fired;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state   <= n_state;
            r_out_changed <= (n_state != r_state);
            r_out_stop    <= r_stop;
            r_out_cycle   <= r_cycle;
        end
    end

    // Checks on the classifier and the result register.
`include "assert_macros.svh"

    `ASSERT_CLK(a_state_only_on_advance, !advance |=> $stable(r_state), "state moved without a tick")
    `ASSERT_CLK(a_held_has_fired, (r_state == tbpc_pkg::ST_STOP_HELD || r_state == tbpc_pkg::ST_CYCLE_HELD || r_state == tbpc_pkg::ST_BOTH_HELD) |-> r_hold_fired, "held state without hold flag")
    `ASSERT_CLK(a_out_drains, (r_out_valid && i_out_ready && !advance) |=> !r_out_valid, "taken result stayed valid")
    `ASSERT_CLK(a_changed_matches, (advance && r_out_valid && i_out_ready) |=> (o_state_changed == ($past(n_state) != $past(r_state))), "changed flag wrong")

endmodule
